FILE: rtl/core/psxpft_pkg.sv
package psxpft_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned BTN_W      = 16;
    localparam int unsigned AXIS_W     = 16;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [BYTE_W-1:0] ID_DIGITAL     = 8'h41;
    localparam logic [BYTE_W-1:0] ID_ANALOG_RED  = 8'h53;
    localparam logic [BYTE_W-1:0] ID_ANALOG_GRN  = 8'h73;
    localparam logic [BYTE_W-1:0] AXIS_CENTER    = 8'h80;
    localparam logic [BYTE_W-1:0] INVALID_LIMIT_RST = 8'd8;

    typedef enum logic {
        OP_FRAME = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANALOG_ENABLE = 1'b0,
        CFG_INVALID_LIMIT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic              analog_enable;
        logic [BYTE_W-1:0] invalid_limit;
    } cfg_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] id_byte;
        logic [BYTE_W-1:0] btn_low_byte;
        logic [BYTE_W-1:0] btn_high_byte;
        logic [BYTE_W-1:0] right_x_byte;
        logic [BYTE_W-1:0] right_y_byte;
        logic [BYTE_W-1:0] left_x_byte;
        logic [BYTE_W-1:0] left_y_byte;
    } item_t;

    typedef struct packed {
        logic signed [AXIS_W-1:0] left_x;
        logic signed [AXIS_W-1:0] left_y;
        logic signed [AXIS_W-1:0] right_x;
        logic signed [AXIS_W-1:0] right_y;
    } axes_t;

    typedef struct packed {
        op_t              op;
        logic             valid_id;
        logic [BTN_W-1:0] buttons;
        axes_t            axes;
    } frame_t;

    typedef struct packed {
        logic             try_alternate;
        logic             select_line;
        logic             frame_ok;
        logic [BTN_W-1:0] held_buttons;
        logic [BTN_W-1:0] pressed_edges;
        logic [BTN_W-1:0] released_edges;
        axes_t            axes;
    } result_t;

    function automatic logic signed [AXIS_W-1:0] center_axis(input logic [BYTE_W-1:0] raw);
        logic [BYTE_W-1:0] flipped;
        flipped = raw ^ AXIS_CENTER;
        return signed'({flipped, {(AXIS_W-BYTE_W){1'b0}}});
    endfunction

endpackage

FILE: rtl/core/psxpft_decode.sv
module psxpft_decode (
    input  psxpft_pkg::item_t  item,
    input  logic               analog_enable,
    output psxpft_pkg::frame_t frame
);
    import psxpft_pkg::*;

    logic analog_id;

    always_comb
    begin
        analog_id      = (item.id_byte == ID_ANALOG_RED) || (item.id_byte == ID_ANALOG_GRN);
        frame.op       = item.op;
        frame.valid_id = analog_id || (item.id_byte == ID_DIGITAL);
        frame.buttons  = ~{item.btn_high_byte, item.btn_low_byte};
        frame.axes     = '0;
        if (analog_enable && analog_id)
        begin
            frame.axes.left_x  = center_axis(item.left_x_byte);
            frame.axes.left_y  = center_axis(item.left_y_byte);
            frame.axes.right_x = center_axis(item.right_x_byte);
            frame.axes.right_y = center_axis(item.right_y_byte);
        end
    end

endmodule

FILE: rtl/core/psxpft_state.sv
module psxpft_state (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  psxpft_pkg::frame_t  frame,
    input  psxpft_pkg::cfg_t    cfg,
    output psxpft_pkg::result_t result
);
    import psxpft_pkg::*;

    logic              line_reg, line_next;
    logic              lock_reg, lock_next;
    logic              probing_reg, probing_next;
    logic [BYTE_W-1:0] streak_reg, streak_next;
    logic [BTN_W-1:0]  buttons_reg, buttons_next;
    logic [BTN_W-1:0]  press_reg, press_next;
    logic [BTN_W-1:0]  release_reg, release_next;
    axes_t             axes_reg, axes_next;

    logic              below_limit;
    logic              do_commit;
    logic [BTN_W-1:0]  commit_buttons;
    axes_t             commit_axes;
    logic [BTN_W-1:0]  press_rep;
    logic [BTN_W-1:0]  release_rep;

    always_comb
    begin
        line_next      = line_reg;
        lock_next      = lock_reg;
        probing_next   = probing_reg;
        streak_next    = streak_reg;
        below_limit    = streak_reg < cfg.invalid_limit;
        do_commit      = 1'b0;
        commit_buttons = frame.buttons;
        commit_axes    = frame.axes;

        if (frame.op == OP_FRAME)
        begin
            if (frame.valid_id)
            begin
                line_next    = line_reg ^ probing_reg;
                probing_next = 1'b0;
                lock_next    = 1'b1;
                streak_next  = '0;
                do_commit    = 1'b1;
            end
            else if (!probing_reg)
            begin
                if (lock_reg && below_limit)
                begin
                    streak_next = streak_reg + 1'b1;
                end
                else
                begin
                    lock_next    = 1'b0;
                    probing_next = 1'b1;
                end
            end
            else
            begin
                probing_next = 1'b0;
                if (below_limit)
                begin
                    streak_next = streak_reg + 1'b1;
                end
                else
                begin
                    do_commit      = 1'b1;
                    commit_buttons = '0;
                    commit_axes    = '0;
                end
            end
        end

        buttons_next = buttons_reg;
        axes_next    = axes_reg;
        press_rep    = press_reg;
        release_rep  = release_reg;
        if (do_commit)
        begin
            press_rep    = press_reg | (commit_buttons & ~buttons_reg);
            release_rep  = release_reg | (~commit_buttons & buttons_reg);
            buttons_next = commit_buttons;
            axes_next    = commit_axes;
        end

        result.try_alternate  = probing_next;
        result.select_line    = line_next ^ probing_next;
        result.frame_ok       = (frame.op == OP_FRAME) && frame.valid_id;
        result.held_buttons   = buttons_next;
        result.pressed_edges  = press_rep;
        result.released_edges = release_rep;
        result.axes           = axes_next;

        press_next   = (frame.op == OP_READ) ? '0 : press_rep;
        release_next = (frame.op == OP_READ) ? '0 : release_rep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg    <= 1'b0;
            lock_reg    <= 1'b0;
            probing_reg <= 1'b0;
            streak_reg  <= '0;
            buttons_reg <= '0;
            press_reg   <= '0;
            release_reg <= '0;
            axes_reg    <= '0;
        end
        else if (step)
        begin
            line_reg    <= line_next;
            lock_reg    <= lock_next;
            probing_reg <= probing_next;
            streak_reg  <= streak_next;
            buttons_reg <= buttons_next;
            press_reg   <= press_next;
            release_reg <= release_next;
            axes_reg    <= axes_next;
        end
    end

endmodule

FILE: rtl/core/psx_pad_frame_tracker_unit.sv
// Pad poll-frame tracker. Each request is either one frame attempt (ID byte, two
// active-low button bytes, four stick bytes) or a read (op = 1) that reports the
// state and clears the press/release edge latches. Every request yields exactly
// one result. Throughput is one request per cycle while the output is not stalled;
// the request sits in the input register while the state update runs, and the result
// register loads as the request advances. in_ready follows out_ready combinationally
// through the two-entry pipeline. Write cfg_index 0 (analog_enable, bit 0 of cfg_data)
// or 1 (invalid_limit) only while no request is in flight; writes are always taken.
module psx_pad_frame_tracker_unit (
    input  logic                                    clk,
    input  logic                                    rst_n,

    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    op,
    input  logic [psxpft_pkg::BYTE_W-1:0]           id_byte,
    input  logic [psxpft_pkg::BYTE_W-1:0]           btn_low_byte,
    input  logic [psxpft_pkg::BYTE_W-1:0]           btn_high_byte,
    input  logic [psxpft_pkg::BYTE_W-1:0]           right_x_byte,
    input  logic [psxpft_pkg::BYTE_W-1:0]           right_y_byte,
    input  logic [psxpft_pkg::BYTE_W-1:0]           left_x_byte,
    input  logic [psxpft_pkg::BYTE_W-1:0]           left_y_byte,

    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic                                    try_alternate,
    output logic                                    select_line,
    output logic                                    frame_ok,
    output logic [psxpft_pkg::BTN_W-1:0]            held_buttons,
    output logic [psxpft_pkg::BTN_W-1:0]            pressed_edges,
    output logic [psxpft_pkg::BTN_W-1:0]            released_edges,
    output logic signed [psxpft_pkg::AXIS_W-1:0]    axis_left_x,
    output logic signed [psxpft_pkg::AXIS_W-1:0]    axis_left_y,
    output logic signed [psxpft_pkg::AXIS_W-1:0]    axis_right_x,
    output logic signed [psxpft_pkg::AXIS_W-1:0]    axis_right_y,

    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [psxpft_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [psxpft_pkg::BYTE_W-1:0]           cfg_data
);
    import psxpft_pkg::*;

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t result_reg;
    logic    out_valid_reg;

    frame_t  frame;
    result_t result;
    logic    advance;

    assign cfg_ready = 1'b1;
    assign advance   = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.analog_enable <= 1'b1;
            cfg_reg.invalid_limit <= INVALID_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ANALOG_ENABLE: cfg_reg.analog_enable <= cfg_data[0];
                CFG_INVALID_LIMIT: cfg_reg.invalid_limit <= cfg_data;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                item_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= '{op:            op_t'(op),
                          id_byte:       id_byte,
                          btn_low_byte:  btn_low_byte,
                          btn_high_byte: btn_high_byte,
                          right_x_byte:  right_x_byte,
                          right_y_byte:  right_y_byte,
                          left_x_byte:   left_x_byte,
                          left_y_byte:   left_y_byte};
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    psxpft_decode u_decode (
        .item          (item_reg),
        .analog_enable (cfg_reg.analog_enable),
        .frame         (frame)
    );

    psxpft_state u_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .frame  (frame),
        .cfg    (cfg_reg),
        .result (result)
    );

    assign out_valid      = out_valid_reg;
    assign try_alternate  = result_reg.try_alternate;
    assign select_line    = result_reg.select_line;
    assign frame_ok       = result_reg.frame_ok;
    assign held_buttons   = result_reg.held_buttons;
    assign pressed_edges  = result_reg.pressed_edges;
    assign released_edges = result_reg.released_edges;
    assign axis_left_x    = result_reg.axes.left_x;
    assign axis_left_y    = result_reg.axes.left_y;
    assign axis_right_x   = result_reg.axes.right_x;
    assign axis_right_y   = result_reg.axes.right_y;

endmodule

FILE: rtl/core/psxpft_checker.sv
module psxpft_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic                                 try_alternate,
    input logic                                 frame_ok,
    input logic [psxpft_pkg::BTN_W-1:0]         held_buttons,
    input logic signed [psxpft_pkg::AXIS_W-1:0] axis_left_x,
    input logic signed [psxpft_pkg::AXIS_W-1:0] axis_left_y,
    input logic signed [psxpft_pkg::AXIS_W-1:0] axis_right_x,
    input logic signed [psxpft_pkg::AXIS_W-1:0] axis_right_y
);
    import psxpft_pkg::*;

    // hold a stalled result
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(held_buttons)
            && $stable(axis_left_x) && $stable(frame_ok))
        else $error("stalled result changed");

    // a good frame ends any probe
    a_ok_no_probe: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_ok |-> !try_alternate)
        else $error("probe pending after good frame");

    // centered axes carry no low byte
    a_axis_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (axis_left_x[BYTE_W-1:0] == '0) && (axis_left_y[BYTE_W-1:0] == '0)
            && (axis_right_x[BYTE_W-1:0] == '0) && (axis_right_y[BYTE_W-1:0] == '0))
        else $error("axis low byte not zero");

endmodule

bind psx_pad_frame_tracker_unit psxpft_checker u_psxpft_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .try_alternate  (try_alternate),
    .frame_ok       (frame_ok),
    .held_buttons   (held_buttons),
    .axis_left_x    (axis_left_x),
    .axis_left_y    (axis_left_y),
    .axis_right_x   (axis_right_x),
    .axis_right_y   (axis_right_y)
);
